@@ rtl/ccf_pkg.sv @@
`timescale 1ns / 1ps

package ccf_pkg;

   localparam int CNT_W = 16;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Characters the filter reacts to
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X      = 8'h78;

   // Character literal tracking, a small signed count toward the literal end
   localparam logic signed [2:0] QUOTE_NONE = 3'sd0;
   localparam logic signed [2:0] QUOTE_OPEN = 3'sd1;
   localparam logic signed [2:0] QUOTE_ESC  = -3'sd4;
   localparam logic signed [2:0] QUOTE_HEX1 = -3'sd3;
   localparam logic signed [2:0] QUOTE_HEX2 = -3'sd2;
   localparam logic signed [2:0] QUOTE_DONE = -3'sd1;

   typedef enum logic [4:0] {
      CMT_NONE  = 5'b00001,
      CMT_SLASH = 5'b00010,
      CMT_LINE  = 5'b00100,
      CMT_BLOCK = 5'b01000,
      CMT_STAR  = 5'b10000
   } cmt_type;

   typedef enum logic [4:0] {
      CONT_NONE    = 5'b00001,
      CONT_BSL     = 5'b00010,
      CONT_BLANK   = 5'b00100,
      CONT_JOINED  = 5'b01000,
      CONT_RELEASE = 5'b10000
   } cont_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             is_end;
      logic [CNT_W-1:0] lines_skipped;
      logic [CNT_W-1:0] cols_skipped;
      logic             last;
   } rsp_type;

   // Up to two result words caused by one input word
   typedef struct packed {
      rsp_type res0;
      rsp_type res1;
      logic    two;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } push_type;

   typedef struct packed {
      cmt_type           cmt;
      cont_type          cont;
      logic              in_str;
      logic signed [2:0] quote;
      logic [CNT_W-1:0]  lines;
      logic [CNT_W-1:0]  cols;
   } state_type;

   localparam state_type STATE_RESET = '{
      cmt: CMT_NONE, cont: CONT_NONE, in_str: 1'b0, quote: QUOTE_NONE,
      lines: '0, cols: '0};

   typedef struct packed {
      state_type  st;
      logic [7:0] o;
      logic       held;
      logic [7:0] held_byte;
   } filt_type;

   function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // One filter step on one byte; o of zero means nothing is emitted
   function automatic filt_type filter_byte(state_type s, logic [7:0] b);
      filt_type f;
      f.st        = s;
      f.o         = CH_NUL;
      f.held      = 1'b0;
      f.held_byte = CH_NUL;
      if (s.cmt != CMT_NONE) begin
         case (b)
            CH_SLASH: begin
               if (s.cmt == CMT_SLASH) begin
                  f.st.cmt  = CMT_LINE;
                  f.st.cols = sat_inc(f.st.cols);
               end else if (s.cmt == CMT_STAR) begin
                  f.st.cmt = CMT_NONE;
               end
               f.st.cols = sat_inc(f.st.cols);
            end
            CH_NL: begin
               if (s.cmt == CMT_SLASH) begin
                  f.st.cmt    = CMT_NONE;
                  f.o         = CH_SLASH;
                  f.held      = 1'b1;
                  f.held_byte = CH_NL;
               end else if (s.cmt == CMT_LINE) begin
                  f.st.cmt = CMT_NONE;
                  f.o      = CH_NL;
               end else begin
                  if (s.cmt == CMT_STAR) f.st.cmt = CMT_BLOCK;
                  f.st.cols  = '0;
                  f.st.lines = sat_inc(f.st.lines);
               end
            end
            CH_STAR: begin
               if (s.cmt == CMT_SLASH) begin
                  f.st.cmt  = CMT_BLOCK;
                  f.st.cols = sat_inc(f.st.cols);
               end else if (s.cmt == CMT_BLOCK) begin
                  f.st.cmt = CMT_STAR;
               end
               f.st.cols = sat_inc(f.st.cols);
            end
            default: begin
               if (s.cmt == CMT_SLASH) begin
                  f.st.cmt    = CMT_NONE;
                  f.o         = CH_SLASH;
                  f.held      = 1'b1;
                  f.held_byte = b;
               end else begin
                  if (s.cmt == CMT_STAR) f.st.cmt = CMT_BLOCK;
                  f.st.cols = sat_inc(f.st.cols);
               end
            end
         endcase
      end else if (s.cont != CONT_NONE) begin
         if (s.cont == CONT_RELEASE) begin
            f.st.cont = CONT_NONE;
            f.o       = b;
         end else begin
            case (b)
               CH_SPACE, CH_TAB: begin
                  if (s.cont == CONT_BSL) begin
                     f.st.cont = CONT_BLANK;
                     f.st.cols = sat_inc(f.st.cols);
                  end
                  f.st.cols = sat_inc(f.st.cols);
               end
               CH_BSLASH: begin
                  if (s.cont == CONT_BSL) begin
                     f.st.cont   = CONT_RELEASE;
                     f.o         = CH_BSLASH;
                     f.held      = 1'b1;
                     f.held_byte = CH_BSLASH;
                  end else begin
                     f.st.cont = CONT_BSL;
                  end
               end
               CH_NL: begin
                  if (s.cont == CONT_JOINED) begin
                     f.st.cont = CONT_NONE;
                     f.o       = CH_NL;
                  end else begin
                     f.st.cont  = CONT_JOINED;
                     f.st.cols  = '0;
                     f.st.lines = sat_inc(f.st.lines);
                  end
               end
               default: begin
                  if (s.cont == CONT_BSL) begin
                     f.st.cont = CONT_RELEASE;
                     f.o       = CH_BSLASH;
                  end else begin
                     f.st.cont = CONT_NONE;
                  end
                  f.held      = 1'b1;
                  f.held_byte = b;
               end
            endcase
         end
      end else begin
         case (b)
            CH_BSLASH: begin
               if (s.quote == QUOTE_NONE) begin
                  f.st.cont = CONT_BSL;
               end else if (s.quote == QUOTE_OPEN) begin
                  f.st.quote = QUOTE_ESC;
                  f.o        = b;
               end else if (s.quote == QUOTE_ESC) begin
                  f.st.quote = QUOTE_DONE;
                  f.o        = b;
               end else begin
                  f.st.quote = QUOTE_NONE;
                  f.st.cont  = CONT_BSL;
                  f.o        = b;
               end
            end
            CH_SLASH: begin
               if (s.quote == QUOTE_OPEN) begin
                  f.st.quote = QUOTE_DONE;
                  f.o        = b;
               end else begin
                  f.st.quote = QUOTE_NONE;
                  if (!s.in_str) f.st.cmt = CMT_SLASH;
                  else f.o = b;
               end
            end
            CH_DQUOTE: begin
               if (s.quote == QUOTE_OPEN || s.quote == QUOTE_ESC) begin
                  f.st.quote = QUOTE_DONE;
               end else begin
                  f.st.quote  = QUOTE_NONE;
                  f.st.in_str = ~s.in_str;
               end
               f.o = b;
            end
            CH_SQUOTE: begin
               if (s.quote == QUOTE_OPEN) f.st.quote = QUOTE_NONE;
               else if (s.quote == QUOTE_ESC) f.st.quote = QUOTE_DONE;
               else f.st.quote = s.in_str ? QUOTE_NONE : QUOTE_OPEN;
               f.o = b;
            end
            default: begin
               if (b == CH_NL) f.st.quote = QUOTE_NONE;
               else if (s.quote == QUOTE_OPEN) f.st.quote = QUOTE_DONE;
               else if (s.quote == QUOTE_ESC)
                  f.st.quote = (b == CH_X) ? QUOTE_HEX1 : QUOTE_DONE;
               else if (s.quote inside {QUOTE_HEX1, QUOTE_HEX2, QUOTE_DONE})
                  f.st.quote = s.quote + 3'sd1;
               f.o = b;
            end
         endcase
      end
      return f;
   endfunction

endpackage

@@ rtl/ccf_front.sv @@
`timescale 1ns / 1ps

module ccf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  ccf_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              req_stall,
   output ccf_pkg::push_type push
);

   ccf_pkg::state_type state_ff, state_in;
   ccf_pkg::filt_type  f1, f2;
   ccf_pkg::state_type s1, s2, s_next;
   ccf_pkg::rsp_type   r0, r1, r_end;
   logic               e0, e1, accept;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   // Filter the byte, then refilter a released byte in the same cycle
   always_comb begin
      f1 = ccf_pkg::filter_byte(state_ff, req_data.in_byte);
      s1 = f1.st;
      e0 = (f1.o != ccf_pkg::CH_NUL);
      r0 = '{out_byte: f1.o, is_end: 1'b0, lines_skipped: s1.lines,
             cols_skipped: s1.cols, last: 1'b0};
      if (e0) begin
         s1.lines = '0;
         s1.cols  = '0;
      end
      f2 = ccf_pkg::filter_byte(s1, f1.held_byte);
      e1 = f1.held & (f2.o != ccf_pkg::CH_NUL);
      s2 = f1.held ? f2.st : s1;
      r1 = '{out_byte: f2.o, is_end: 1'b0, lines_skipped: s2.lines,
             cols_skipped: s2.cols, last: 1'b1};
      if (e1) begin
         s2.lines = '0;
         s2.cols  = '0;
      end
      r_end = '{out_byte: ccf_pkg::CH_NUL, is_end: 1'b1,
                lines_skipped: state_ff.lines, cols_skipped: state_ff.cols,
                last: 1'b1};
   end

   // Pack the results of this word for the back end
   always_comb begin
      push.valid      = 1'b0;
      push.bundle     = '0;
      s_next          = s2;
      if (req_data.end_of_input) begin
         s_next          = state_ff;
         s_next.lines    = '0;
         s_next.cols     = '0;
         push.valid      = accept;
         push.bundle.res0 = r_end;
      end else if (e0 && e1) begin
         push.valid       = accept;
         push.bundle.res0 = r0;
         push.bundle.res1 = r1;
         push.bundle.two  = 1'b1;
      end else if (e0) begin
         push.valid            = accept;
         push.bundle.res0      = r0;
         push.bundle.res0.last = 1'b1;
      end else if (e1) begin
         push.valid       = accept;
         push.bundle.res0 = r1;
      end
      state_in = accept ? s_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccf_pkg::STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.end_of_input |-> push.valid && push.bundle.res0.is_end)
      else $error("end of input did not produce a result");

   a_held_release: assert property (@(posedge clock) disable iff (reset)
      push.valid && push.bundle.two |-> !push.bundle.res0.last && push.bundle.res1.last)
      else $error("two-result word carries wrong last flags");

endmodule

@@ rtl/ccf_queue.sv @@
`timescale 1ns / 1ps

module ccf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  ccf_pkg::push_type   push,
   input  logic                pop,
   output logic                full,
   output logic                nonempty,
   output ccf_pkg::bundle_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ccf_pkg::bundle_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign nonempty = (count_ff != '0);
   assign head     = mem_ff[rd_ptr_ff];
   assign do_push  = push.valid & ~full;
   assign do_pop   = pop & nonempty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push.bundle;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue occupancy out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("push into full queue");

endmodule

@@ rtl/ccf_back.sv @@
`timescale 1ns / 1ps

module ccf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                nonempty,
   input  ccf_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ccf_pkg::rsp_type    rsp_data
);

   ccf_pkg::bundle_type cur_ff, cur_in;
   logic                valid_ff, valid_in;
   logic                sel_ff, sel_in;
   logic                fire, done, load;

   assign rsp_valid = valid_ff;
   assign rsp_data  = sel_ff ? cur_ff.res1 : cur_ff.res0;
   assign fire      = valid_ff & ~rsp_stall;
   assign done      = fire & (sel_ff | ~cur_ff.two);
   assign load      = ~valid_ff | done;
   assign pop       = load & nonempty;

   // Load the next bundle when the current one is drained, else step to its second word
   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         cur_in   = head;
         valid_in = nonempty;
         sel_in   = 1'b0;
      end else if (fire) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      fire && !sel_ff && cur_ff.two |=> rsp_valid && sel_ff && rsp_data.last)
      else $error("second word of a pair not presented");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_end |-> rsp_data.last)
      else $error("end-of-stream word without last");

endmodule

@@ rtl/comment_continuation_filter_unit.sv @@
// Comment and line-continuation filter for a source byte stream.
// req channel: one raw byte per word (in_byte), or an end-of-stream marker
//   (end_of_input, byte ignored). A word is taken when req_valid is high
//   and req_stall is low.
// rsp channel: filtered bytes with the counts of lines and columns that
//   were swallowed before them. A word goes out when rsp_valid is high and
//   rsp_stall is low. One input word yields zero, one or two output words;
//   last marks the final one. NUL bytes and comments yield none.
// An input word is written into the queue, then into the output register.
// Throughput: one input word per cycle while the queue is not full; a word
//   releasing a held slash or backslash yields up to two output words.
// A queue of QUEUE_DEPTH entries sits between the filter front end and the
//   output stage. When the receiver stalls, the queue fills and req_stall
//   rises only once it is full.
// Reset clears all comment, continuation, string and quote modes, the skip
//   counters and the queue; no output word is valid after reset.
`timescale 1ns / 1ps

module comment_continuation_filter_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ccf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ccf_pkg::rsp_type rsp_data
);

   ccf_pkg::push_type   push;
   ccf_pkg::bundle_type head;
   logic                q_full, q_nonempty, q_pop;

   // Filter and classify incoming bytes
   ccf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .req_stall (req_stall),
      .push      (push)
   );

   // Decouple the front end from the output stage
   ccf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (q_pop),
      .full     (q_full),
      .nonempty (q_nonempty),
      .head     (head)
   );

   // Emit result words one at a time
   ccf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .nonempty  (q_nonempty),
      .head      (head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   import ccf_pkg::*;

   localparam int RANDOM_WORDS = 1050;
   localparam int LIMIT_CYCLES = 1000000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bit idling     = 1'b0;
   int errors     = 0;
   int words_sent = 0;
   int cycles     = 0;

   // Filter state as predicted from the accepted input words
   cmt_type           cmt_st     = CMT_NONE;
   cont_type          cont_st    = CONT_NONE;
   logic              str_st     = 1'b0;
   logic signed [2:0] chr_st     = QUOTE_NONE;
   logic [CNT_W-1:0]  skip_lines = '0;
   logic [CNT_W-1:0]  skip_cols  = '0;
   rsp_type           expected_words[$];

   comment_continuation_filter_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Saturating skip counters
   function automatic void skip_column();
      if (skip_cols != CNT_MAX) skip_cols++;
   endfunction

   function automatic void skip_newline();
      skip_cols = '0;
      if (skip_lines != CNT_MAX) skip_lines++;
   endfunction

   // Build one result word carrying the swallowed counts, then clear them
   function automatic rsp_type take_counts(logic [7:0] b, logic is_end);
      rsp_type r;
      r.out_byte      = b;
      r.is_end        = is_end;
      r.lines_skipped = skip_lines;
      r.cols_skipped  = skip_cols;
      r.last          = 1'b0;
      skip_lines      = '0;
      skip_cols       = '0;
      return r;
   endfunction

   function automatic logic is_blank(logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB);
   endfunction

   // Advance the predicted modes by one byte; emit of NUL means nothing comes out
   function automatic void filter_char(input logic [7:0] b, output logic [7:0] emit,
                                       output logic hold, output logic [7:0] held);
      emit = CH_NUL;
      hold = 1'b0;
      held = CH_NUL;
      if (cmt_st != CMT_NONE) begin
         case (cmt_st)
            CMT_SLASH: begin
               if (b == CH_SLASH || b == CH_STAR) begin
                  cmt_st = (b == CH_SLASH) ? CMT_LINE : CMT_BLOCK;
                  skip_column();
                  skip_column();
               end else begin
                  // lone slash: release it and rescan this byte
                  cmt_st = CMT_NONE;
                  emit   = CH_SLASH;
                  hold   = 1'b1;
                  held   = b;
               end
            end
            CMT_LINE: begin
               if (b == CH_NL) begin
                  cmt_st = CMT_NONE;
                  emit   = CH_NL;
               end else begin
                  skip_column();
               end
            end
            CMT_BLOCK: begin
               if (b == CH_NL) begin
                  skip_newline();
               end else begin
                  if (b == CH_STAR) cmt_st = CMT_STAR;
                  skip_column();
               end
            end
            default: begin
               // star seen inside a block comment
               if (b == CH_NL) begin
                  cmt_st = CMT_BLOCK;
                  skip_newline();
               end else begin
                  if (b == CH_SLASH) cmt_st = CMT_NONE;
                  else if (b != CH_STAR) cmt_st = CMT_BLOCK;
                  skip_column();
               end
            end
         endcase
      end else if (cont_st != CONT_NONE) begin
         case (cont_st)
            CONT_RELEASE: begin
               cont_st = CONT_NONE;
               emit    = b;
            end
            CONT_BSL: begin
               if (is_blank(b)) begin
                  cont_st = CONT_BLANK;
                  skip_column();
                  skip_column();
               end else if (b == CH_NL) begin
                  cont_st = CONT_JOINED;
                  skip_newline();
               end else begin
                  cont_st = CONT_RELEASE;
                  emit    = CH_BSLASH;
                  hold    = 1'b1;
                  held    = b;
               end
            end
            default: begin
               // blanks after the backslash, or a line already joined
               if (is_blank(b)) begin
                  skip_column();
               end else if (b == CH_BSLASH) begin
                  cont_st = CONT_BSL;
               end else if (b == CH_NL) begin
                  if (cont_st == CONT_JOINED) begin
                     cont_st = CONT_NONE;
                     emit    = CH_NL;
                  end else begin
                     cont_st = CONT_JOINED;
                     skip_newline();
                  end
               end else begin
                  cont_st = CONT_NONE;
                  hold    = 1'b1;
                  held    = b;
               end
            end
         endcase
      end else begin
         case (b)
            CH_BSLASH: begin
               if (chr_st == QUOTE_NONE) begin
                  cont_st = CONT_BSL;
               end else if (chr_st == QUOTE_OPEN) begin
                  chr_st = QUOTE_ESC;
                  emit   = b;
               end else if (chr_st == QUOTE_ESC) begin
                  chr_st = QUOTE_DONE;
                  emit   = b;
               end else begin
                  chr_st  = QUOTE_NONE;
                  cont_st = CONT_BSL;
                  emit    = b;
               end
            end
            CH_SLASH: begin
               if (chr_st == QUOTE_OPEN) begin
                  chr_st = QUOTE_DONE;
                  emit   = b;
               end else begin
                  chr_st = QUOTE_NONE;
                  if (str_st) emit = b;
                  else cmt_st = CMT_SLASH;
               end
            end
            CH_DQUOTE: begin
               if (chr_st == QUOTE_OPEN || chr_st == QUOTE_ESC) begin
                  chr_st = QUOTE_DONE;
               end else begin
                  chr_st = QUOTE_NONE;
                  str_st = !str_st;
               end
               emit = b;
            end
            CH_SQUOTE: begin
               if (chr_st == QUOTE_OPEN) chr_st = QUOTE_NONE;
               else if (chr_st == QUOTE_ESC) chr_st = QUOTE_DONE;
               else chr_st = str_st ? QUOTE_NONE : QUOTE_OPEN;
               emit = b;
            end
            default: begin
               if (b == CH_NL) begin
                  chr_st = QUOTE_NONE;
               end else begin
                  case (chr_st)
                     QUOTE_OPEN: chr_st = QUOTE_DONE;
                     QUOTE_ESC:  chr_st = (b == CH_X) ? QUOTE_HEX1 : QUOTE_DONE;
                     QUOTE_HEX1: chr_st = QUOTE_HEX2;
                     QUOTE_HEX2: chr_st = QUOTE_DONE;
                     QUOTE_DONE: chr_st = QUOTE_NONE;
                     default:    chr_st = chr_st;
                  endcase
               end
               emit = b;
            end
         endcase
      end
   endfunction

   // Queue the result words that one accepted input word will cause
   function automatic void predict_word(req_type w);
      rsp_type    words[2];
      int         n;
      logic [7:0] o;
      logic [7:0] held;
      logic [7:0] unused_b;
      logic       hold;
      logic       unused_h;
      n = 0;
      if (w.end_of_input) begin
         words[0] = take_counts(CH_NUL, 1'b1);
         n = 1;
      end else begin
         filter_char(w.in_byte, o, hold, held);
         if (o != CH_NUL) begin
            words[n] = take_counts(o, 1'b0);
            n++;
         end
         if (hold) begin
            filter_char(held, o, unused_h, unused_b);
            if (o != CH_NUL) begin
               words[n] = take_counts(o, 1'b0);
               n++;
            end
         end
      end
      if (n > 0) words[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_words.push_back(words[i]);
   endfunction

   // Drive one input word and wait until it is taken
   task automatic send_word(req_type w);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(w);
      words_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      send_word('{in_byte: b, end_of_input: 1'b0});
   endtask

   task automatic send_end();
      send_word('{in_byte: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] pick_char(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   // Directed: block comment closed by a star run, line comment, lone slash
   task automatic test_comments();
      send_text("/*a**///\n/q");
   endtask

   // Directed: joined line with blanks, double backslash, backslash released
   task automatic test_continuations();
      send_text("\\ \n\\\\\\q");
   endtask

   // Directed: hex escape in a character literal, slash inside a string
   task automatic test_literals();
      send_text("'\\x4F'\"/\"");
   endtask

   // Directed: NUL, top byte value, end of stream with a slash still held
   task automatic test_end_and_nul();
      send_byte(CH_NUL);
      send_byte(8'hFF);
      send_byte(CH_SLASH);
      send_end();
      send_byte(CH_NL);
      send_end();
   endtask

   // One random source fragment, mostly well formed
   task automatic send_fragment();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 22) begin
         repeat ($urandom_range(1, 6)) send_byte(pick_char("abcxyz_019 \t;("));
      end else if (kind < 32) begin
         send_text("//");
         repeat ($urandom_range(0, 8)) send_byte(pick_char("a*/\\\"'"));
         send_byte(CH_NL);
      end else if (kind < 45) begin
         send_text("/*");
         repeat ($urandom_range(0, 10)) send_byte(pick_char("ab*/\n\"'\\"));
         repeat ($urandom_range(1, 3)) send_byte(CH_STAR);
         send_byte(CH_SLASH);
      end else if (kind < 55) begin
         send_byte(CH_DQUOTE);
         repeat ($urandom_range(0, 6)) send_byte(pick_char("a/*'\\x"));
         send_byte(CH_DQUOTE);
      end else if (kind < 66) begin
         send_byte(CH_SQUOTE);
         case ($urandom_range(0, 6))
            0: send_byte(pick_char("az09 "));
            1: send_byte(CH_SLASH);
            2: send_byte(CH_DQUOTE);
            3: send_text({"\\", string'(pick_char("ntr0"))});
            4: send_text({"\\x", string'(pick_char("0123456789abcdefABCDEF")),
                          string'(pick_char("0123456789abcdefABCDEF"))});
            5: send_text("\\\\");
            default: send_text("\\'");
         endcase
         send_byte(CH_SQUOTE);
      end else if (kind < 74) begin
         send_byte(CH_BSLASH);
         repeat ($urandom_range(0, 3)) send_byte(pick_char(" \t"));
         send_byte(CH_NL);
         if ($urandom_range(0, 1) == 0) send_byte(CH_NL);
      end else if (kind < 78) begin
         send_byte(CH_NL);
      end else if (kind < 88) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 91) begin
         send_byte(CH_NUL);
      end else if (kind < 96) begin
         send_byte(pick_char("/\\"));
         send_byte(8'($urandom_range(0, 255)));
      end else begin
         send_end();
      end
   endtask

   // Random source in segments, idling on or off per segment, none at the tail
   task automatic test_random_source();
      int seg_end;
      while (words_sent < RANDOM_WORDS) begin
         idling  = (words_sent < RANDOM_WORDS - 150) && ($urandom_range(0, 3) != 0);
         seg_end = words_sent + 60;
         while (words_sent < seg_end && words_sent < RANDOM_WORDS) send_fragment();
      end
      idling = 1'b0;
   endtask

   // Stall the result side in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idling && !reset && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each result word with the oldest expected one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word %p", rsp_data);
            errors++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte expected %0h actual %0h", want.out_byte, rsp_data.out_byte);
               errors++;
            end
            if (rsp_data.is_end !== want.is_end) begin
               $error("is_end expected %0b actual %0b", want.is_end, rsp_data.is_end);
               errors++;
            end
            if (rsp_data.lines_skipped !== want.lines_skipped) begin
               $error("lines_skipped expected %0d actual %0d",
                      want.lines_skipped, rsp_data.lines_skipped);
               errors++;
            end
            if (rsp_data.cols_skipped !== want.cols_skipped) begin
               $error("cols_skipped expected %0d actual %0d",
                      want.cols_skipped, rsp_data.cols_skipped);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last expected %0b actual %0b", want.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // Hard stop on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset  <= 1'b0;
      idling = 1'b1;
      test_comments();
      test_continuations();
      test_literals();
      test_end_and_nul();
      test_random_source();
      req_valid <= 1'b0;
      // drain, then give the output queue time to show any extra word
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
